>>> rtl/tcem_pkg.sv
// ----------------------------------------------------------------------------
// Two-counter event monitor package
// Sizes, register layout and operation codes shared by the monitor RTL.
// ----------------------------------------------------------------------------
`default_nettype none

package tcem_pkg;

  localparam int unsigned NUM_COUNTERS = 2;
  localparam int unsigned NUM_EVENTS   = 23;

  localparam int unsigned OP_W    = 2;
  localparam int unsigned IDX_W   = 2;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned SEL_W   = 8;
  localparam int unsigned EV_IDX_W = (NUM_EVENTS > 1) ? $clog2(NUM_EVENTS) : 1;

  localparam int unsigned IN_W       = OP_W + IDX_W + WORD_W + NUM_EVENTS;
  localparam int unsigned IN_TDATA_W = ((IN_W + 7) / 8) * 8;
  localparam int unsigned OUT_W       = WORD_W + 1;
  localparam int unsigned OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;
  localparam int unsigned OUT_PAD_W   = OUT_TDATA_W - OUT_W;

  localparam logic [OP_W-1:0] OP_READ  = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK  = 2'd2;

  localparam logic [IDX_W-1:0] REG_CONTROL = 2'd0;

  localparam int unsigned CTL_ENABLE_BIT = 0;
  localparam int unsigned CTL_RESET_BIT  = 1;
  localparam int unsigned CTL_INTEN_BIT  = 4;
  localparam int unsigned CTL_FLAG_BIT   = 8;

  localparam logic [SEL_W-1:0] SELECT_ALL = 8'hff;

  localparam int unsigned SEL_SHIFT [2] = '{20, 12};

endpackage

`default_nettype wire

>>> rtl/two_counter_event_monitor.sv
// ----------------------------------------------------------------------------
// Two-counter event monitor
// Control register and two 32-bit event counters driven by a word stream.
// ----------------------------------------------------------------------------
// Each input word is a register read, a register write, one tick that
// carries the event lines or an unused code that changes nothing; s_tdata
// holds operation, reg_index, write_data and event_lines from the lowest bit
// up. Every input word yields exactly one output word on the master side
// carrying read_data and irq. A word is taken into an input register; when
// the output register is free or being emptied, the control logic updates the
// register file and loads the output register. One word is accepted every
// cycle while m_tready stays high; the register-file update is one 32-bit
// increment and all-ones check per counter.
// When the receiver stalls, the output register holds its word and the input
// register fills; s_tready falls only when both are occupied and m_tready is
// low. Reset clears the pipeline valid bits, the control register and both
// counters.
// ----------------------------------------------------------------------------
`default_nettype none

module two_counter_event_monitor (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  // operation, reg_index, write_data, event_lines, zero pad
  input  wire logic [tcem_pkg::IN_TDATA_W-1:0]  s_tdata,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  // read_data, irq, zero pad
  output logic [tcem_pkg::OUT_TDATA_W-1:0]      m_tdata
);
  import tcem_pkg::*;

  logic                  in_valid;
  logic [OP_W-1:0]       in_op;
  logic [IDX_W-1:0]      in_idx;
  logic [WORD_W-1:0]     in_wdata;
  logic [NUM_EVENTS-1:0] in_lines;

  logic              out_valid;
  logic [WORD_W-1:0] out_rd;
  logic              out_irq;

  logic                    count_enable, count_enable_next;
  logic [NUM_COUNTERS-1:0] inten, inten_next;
  logic [NUM_COUNTERS-1:0] flags, flags_next;
  logic [SEL_W-1:0]        sel [NUM_COUNTERS];
  logic [SEL_W-1:0]        sel_next [NUM_COUNTERS];
  logic [WORD_W-1:0]       cnt [NUM_COUNTERS];
  logic [WORD_W-1:0]       cnt_next [NUM_COUNTERS];
  logic [WORD_W-1:0]       rd_next;
  logic                    irq_next;

  logic advance;
  logic in_take;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;
  assign in_take  = s_tvalid && s_tready;

  assign m_tvalid = out_valid;
  assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_irq, out_rd};

  always_comb begin
    logic hit;
    logic [WORD_W-1:0] ctl;
    hit = 1'b0;
    count_enable_next = count_enable;
    inten_next = inten;
    flags_next = flags;
    sel_next = sel;
    cnt_next = cnt;
    rd_next = '0;
    ctl = '0;
    ctl[CTL_ENABLE_BIT] = count_enable;
    for (int i = 0; i < NUM_COUNTERS; i++) begin
      ctl[CTL_INTEN_BIT + i] = inten[i];
      ctl[CTL_FLAG_BIT + i] = flags[i];
      ctl[SEL_SHIFT[i] +: SEL_W] = sel[i];
    end
    case (in_op)
      OP_READ: begin
        if (in_idx == REG_CONTROL) begin
          rd_next = ctl;
        end
        for (int i = 0; i < NUM_COUNTERS; i++) begin
          if (in_idx == IDX_W'(i + 1)) begin
            rd_next = cnt[i];
          end
        end
      end
      OP_WRITE: begin
        if (in_idx == REG_CONTROL) begin
          count_enable_next = in_wdata[CTL_ENABLE_BIT];
          for (int i = 0; i < NUM_COUNTERS; i++) begin
            inten_next[i] = in_wdata[CTL_INTEN_BIT + i];
            if (in_wdata[CTL_FLAG_BIT + i]) begin
              flags_next[i] = 1'b0;
            end
            sel_next[i] = in_wdata[SEL_SHIFT[i] +: SEL_W];
            if (in_wdata[CTL_RESET_BIT]) begin
              cnt_next[i] = '0;
            end
          end
        end
        for (int i = 0; i < NUM_COUNTERS; i++) begin
          if (in_idx == IDX_W'(i + 1)) begin
            cnt_next[i] = in_wdata;
          end
        end
      end
      OP_TICK: begin
        if (count_enable) begin
          for (int i = 0; i < NUM_COUNTERS; i++) begin
            if (sel[i] == SELECT_ALL) begin
              hit = 1'b1;
            end else if (sel[i] < SEL_W'(NUM_EVENTS)) begin
              hit = in_lines[sel[i][EV_IDX_W-1:0]];
            end else begin
              hit = 1'b0;
            end
            if (hit) begin
              cnt_next[i] = cnt[i] + WORD_W'(1);
              if (&cnt[i]) begin
                flags_next[i] = 1'b1;
              end
            end
          end
        end
      end
      default: begin
      end
    endcase
    irq_next = |(flags_next & inten_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      out_valid <= 1'b0;
      count_enable <= 1'b0;
      inten <= '0;
      flags <= '0;
      for (int i = 0; i < NUM_COUNTERS; i++) begin
        sel[i] <= '0;
        cnt[i] <= '0;
      end
    end else begin
      if (in_take) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
        count_enable <= count_enable_next;
        inten <= inten_next;
        flags <= flags_next;
        sel <= sel_next;
        cnt <= cnt_next;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_op <= s_tdata[OP_W-1:0];
      in_idx <= s_tdata[OP_W +: IDX_W];
      in_wdata <= s_tdata[OP_W + IDX_W +: WORD_W];
      in_lines <= s_tdata[OP_W + IDX_W + WORD_W +: NUM_EVENTS];
    end
    if (advance) begin
      out_rd <= rd_next;
      out_irq <= irq_next;
    end
  end

endmodule

`default_nettype wire

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// Two-counter event monitor testbench
// Streams register reads, register writes and event ticks into the monitor.
// Each accepted word is run through a behavioral copy of the register file.
// Every output word is compared against the oldest predicted word.
// Random backpressure and source gaps are applied on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

  import tcem_pkg::*;

  localparam logic [OP_W-1:0]  OP_UNUSED   = 2'd3;
  localparam logic [IDX_W-1:0] REG_COUNT_A = 2'd1;
  localparam logic [IDX_W-1:0] REG_COUNT_B = 2'd2;
  localparam logic [IDX_W-1:0] REG_NONE    = 2'd3;

  typedef struct {
    logic [OP_W-1:0]       op;
    logic [IDX_W-1:0]      idx;
    logic [WORD_W-1:0]     data;
    logic [NUM_EVENTS-1:0] lines;
    bit                    drain;
  } mon_cmd_t;

  typedef struct {
    logic [WORD_W-1:0] read_data;
    logic              irq;
  } mon_word_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  mon_cmd_t  pending_cmds[$];
  mon_word_t expected_words[$];
  int unsigned errors = 0;

  // Shadow register file.
  bit            sh_enable;
  bit [1:0]      sh_inten;
  bit [1:0]      sh_flags;
  bit [7:0]      sh_select[2];
  bit [31:0]     sh_count[2];

  two_counter_event_monitor u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic mon_word_t apply_command(input mon_cmd_t c);
    mon_word_t w;
    bit [7:0]  s;
    bit        hit;
    w.read_data = '0;
    case (c.op)
      OP_READ: begin
        if (c.idx == REG_CONTROL) begin
          w.read_data[CTL_ENABLE_BIT] = sh_enable;
          for (int i = 0; i < 2; i++) begin
            w.read_data[CTL_INTEN_BIT+i] = sh_inten[i];
            w.read_data[CTL_FLAG_BIT+i] = sh_flags[i];
            w.read_data[SEL_SHIFT[i]+:8] = sh_select[i];
          end
        end else if (c.idx == REG_COUNT_A) begin
          w.read_data = sh_count[0];
        end else if (c.idx == REG_COUNT_B) begin
          w.read_data = sh_count[1];
        end
      end
      OP_WRITE: begin
        if (c.idx == REG_CONTROL) begin
          sh_enable = c.data[CTL_ENABLE_BIT];
          for (int i = 0; i < 2; i++) begin
            sh_inten[i] = c.data[CTL_INTEN_BIT+i];
            if (c.data[CTL_FLAG_BIT+i]) sh_flags[i] = 1'b0;
            sh_select[i] = c.data[SEL_SHIFT[i]+:8];
            if (c.data[CTL_RESET_BIT]) sh_count[i] = '0;
          end
        end else if (c.idx == REG_COUNT_A) begin
          sh_count[0] = c.data;
        end else if (c.idx == REG_COUNT_B) begin
          sh_count[1] = c.data;
        end
      end
      OP_TICK: begin
        if (sh_enable) begin
          for (int i = 0; i < 2; i++) begin
            s = sh_select[i];
            hit = (s == SELECT_ALL) || (s < NUM_EVENTS && c.lines[s[4:0]]);
            if (hit) begin
              sh_count[i] = sh_count[i] + 1;
              if (sh_count[i] == 0) sh_flags[i] = 1'b1;
            end
          end
        end
      end
      default: begin
      end
    endcase
    w.irq = |(sh_flags & sh_inten);
    return w;
  endfunction

  task automatic queue_cmd(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                           input logic [WORD_W-1:0] data,
                           input logic [NUM_EVENTS-1:0] lines);
    mon_cmd_t c;
    c.op = op;
    c.idx = idx;
    c.data = data;
    c.lines = lines;
    c.drain = 1'b0;
    pending_cmds.push_back(c);
  endtask

  function automatic logic [31:0] control_word(input bit en, input bit clr_counts,
                                               input bit [1:0] inten,
                                               input bit [1:0] clr_flags,
                                               input bit [7:0] sel_a,
                                               input bit [7:0] sel_b);
    logic [31:0] d;
    d = '0;
    d[CTL_ENABLE_BIT] = en;
    d[CTL_RESET_BIT] = clr_counts;
    d[CTL_INTEN_BIT+:2] = inten;
    d[CTL_FLAG_BIT+:2] = clr_flags;
    d[SEL_SHIFT[0]+:8] = sel_a;
    d[SEL_SHIFT[1]+:8] = sel_b;
    return d;
  endfunction

  function automatic bit [7:0] pick_select();
    case ($urandom_range(0, 9))
      6, 7:    return SELECT_ALL;
      8:       return 8'($urandom_range(NUM_EVENTS, 254));
      9:       return 8'($urandom);
      default: return 8'($urandom_range(0, NUM_EVENTS - 1));
    endcase
  endfunction

  function automatic logic [NUM_EVENTS-1:0] pick_lines();
    case ($urandom_range(0, 5))
      0:       return '1;
      1:       return '0;
      2:       return NUM_EVENTS'(1) << $urandom_range(0, NUM_EVENTS - 1);
      default: return NUM_EVENTS'($urandom);
    endcase
  endfunction

  task automatic build_stimulus();
    logic [31:0] d;
    int unsigned n;
    // Reset state, an unmapped read and a tick while counting is off.
    queue_cmd(OP_READ, REG_CONTROL, '0, '0);
    queue_cmd(OP_READ, REG_COUNT_A, '1, '1);
    queue_cmd(OP_READ, REG_COUNT_B, '0, '0);
    queue_cmd(OP_READ, REG_NONE, '0, '0);
    queue_cmd(OP_TICK, REG_CONTROL, '0, '1);
    // Both counters one or two ticks short of wrapping.
    queue_cmd(OP_WRITE, REG_CONTROL, control_word(1, 0, 2'b11, 2'b00, 8'd0, 8'd22), '0);
    queue_cmd(OP_WRITE, REG_COUNT_A, 32'hffff_ffff, '0);
    queue_cmd(OP_WRITE, REG_COUNT_B, 32'hffff_fffe, '0);
    queue_cmd(OP_TICK, REG_CONTROL, '0, '1);
    queue_cmd(OP_TICK, REG_CONTROL, '1, '0);
    queue_cmd(OP_TICK, REG_CONTROL, '0, NUM_EVENTS'(1) << (NUM_EVENTS - 1));
    queue_cmd(OP_READ, REG_CONTROL, '0, '0);
    // Clear one flag, count every tick on A and an unknown code on B.
    queue_cmd(OP_WRITE, REG_CONTROL, control_word(1, 0, 2'b10, 2'b01, SELECT_ALL, 8'd23), '0);
    queue_cmd(OP_TICK, REG_CONTROL, '0, '0);
    queue_cmd(OP_READ, REG_COUNT_A, '0, '0);
    queue_cmd(OP_READ, REG_COUNT_B, '0, '0);
    // Clear the other flag and zero both counters in the same write.
    queue_cmd(OP_WRITE, REG_CONTROL, control_word(0, 1, 2'b01, 2'b10, 8'd5, 8'd0), '0);
    queue_cmd(OP_READ, REG_CONTROL, '0, '0);
    queue_cmd(OP_WRITE, REG_NONE, '1, '1);
    queue_cmd(OP_READ, REG_NONE, '1, '1);
    queue_cmd(OP_UNUSED, REG_NONE, '1, '1);
    queue_cmd(OP_WRITE, REG_CONTROL, '1, '0);
    queue_cmd(OP_READ, REG_CONTROL, '0, '0);
    queue_cmd(OP_WRITE, REG_CONTROL, '0, '0);
    queue_cmd(OP_READ, REG_CONTROL, '0, '0);
    pending_cmds[pending_cmds.size()-1].drain = 1'b1;

    while (pending_cmds.size() < 1725) begin
      case ($urandom_range(0, 9))
        7, 8: begin
          repeat ($urandom_range(1, 4)) begin
            queue_cmd($urandom_range(0, 1) ? OP_WRITE : OP_READ,
                      IDX_W'($urandom_range(1, 2)), $urandom, pick_lines());
          end
        end
        9: begin
          queue_cmd(OP_W'($urandom_range(0, 3)), IDX_W'($urandom_range(0, 3)),
                    $urandom, NUM_EVENTS'($urandom));
        end
        default: begin
          d = $urandom;
          d[CTL_ENABLE_BIT] = ($urandom_range(0, 7) != 0);
          d[CTL_RESET_BIT] = ($urandom_range(0, 7) == 0);
          d[SEL_SHIFT[0]+:8] = pick_select();
          d[SEL_SHIFT[1]+:8] = pick_select();
          queue_cmd(OP_WRITE, REG_CONTROL, d, pick_lines());
          if ($urandom_range(0, 1)) begin
            queue_cmd(OP_WRITE, IDX_W'($urandom_range(1, 2)),
                      32'hffff_ffff - $urandom_range(0, 6), pick_lines());
          end
          n = $urandom_range(1, 12);
          repeat (n) begin
            if ($urandom_range(0, 4) == 0) begin
              queue_cmd(OP_READ, IDX_W'($urandom_range(0, 2)), $urandom, pick_lines());
            end else begin
              queue_cmd(OP_TICK, IDX_W'($urandom_range(0, 3)), $urandom, pick_lines());
            end
          end
          queue_cmd(OP_READ, REG_CONTROL, $urandom, pick_lines());
        end
      endcase
    end
    pending_cmds[pending_cmds.size()/2].drain = 1'b1;
  endtask

  // Source side: one word in flight on the bus, refilled from the pending queue.
  mon_cmd_t    cur_cmd;
  int unsigned src_gap = 0;
  int unsigned words_sent = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
      src_gap = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_words.push_back(apply_command(cur_cmd));
        words_sent++;
        src_gap = (words_sent[7:6] == 2'b11) ? 0 : $urandom_range(0, 3);
      end
      if (!s_tvalid || s_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          s_tvalid <= 1'b0;
        end else if (pending_cmds.size() != 0 &&
                     !(pending_cmds[0].drain && expected_words.size() != 0)) begin
          cur_cmd = pending_cmds.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {{(IN_TDATA_W - IN_W){1'b0}}, cur_cmd.lines, cur_cmd.data,
                      cur_cmd.idx, cur_cmd.op};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Sink side: checks each output word and draws its own stalls.
  int unsigned sink_gap = 0;
  int unsigned sink_hold = 0;
  int unsigned words_seen = 0;

  always @(posedge clk) begin : sink
    mon_word_t got;
    mon_word_t want;
    logic      ready_next;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.read_data = m_tdata[WORD_W-1:0];
        got.irq = m_tdata[WORD_W];
        if (expected_words.size() == 0) begin
          $error("unexpected word: read_data %h irq %b", got.read_data, got.irq);
          errors++;
        end else begin
          want = expected_words.pop_front();
          if (got.read_data !== want.read_data) begin
            $error("read_data expected %h actual %h", want.read_data, got.read_data);
            errors++;
          end
          if (got.irq !== want.irq) begin
            $error("irq expected %b actual %b", want.irq, got.irq);
            errors++;
          end
        end
        words_seen++;
        sink_gap = (words_seen[7:6] == 2'b10) ? 0 : $urandom_range(0, 3);
        if (words_seen == 400 || words_seen == 1300) sink_hold = 60;
      end
      if (sink_hold > 0) begin
        sink_hold--;
        ready_next = 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        ready_next = 1'b0;
      end else begin
        ready_next = 1'b1;
      end
      m_tready <= ready_next;
    end
  end

  initial begin
    sh_enable = 1'b0;
    sh_inten = '0;
    sh_flags = '0;
    sh_select[0] = '0;
    sh_select[1] = '0;
    sh_count[0] = '0;
    sh_count[1] = '0;
    build_stimulus();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    while (pending_cmds.size() != 0 || s_tvalid || expected_words.size() != 0) begin
      @(posedge clk);
    end
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("[two_counter_event_monitor] OK");
    end else begin
      $display("[two_counter_event_monitor] ERROR");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("[two_counter_event_monitor] ERROR");
    $finish;
  end

endmodule
